[hw/rtl/improved_svf_multimode_assert.svh]
// Assertion macros shared by the filter's RTL files.
`ifndef IMPROVED_SVF_MULTIMODE_ASSERT_SVH
`define IMPROVED_SVF_MULTIMODE_ASSERT_SVH

// Clocked check that is switched off while reset is held.
`define ISVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds while reset is held.
`define ISVF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

[hw/rtl/isvf_pkg.sv]
// Shared types and constants for the state variable filter.
`default_nettype none

package isvf_pkg;

  // Configuration register indices.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd2;

  // Damping reset value, about the square root of two, with 16 fraction bits.
  localparam int DAMP_RESET_Q16 = 92682;
  localparam int DAMP_RESET_FRAC = 16;

  // Phases of the shared coefficient multiplier.
  typedef enum logic [2:0] {
    MP_IDLE,
    MP_LO,
    MP_HI,
    MP_SUM,
    MP_NEG
  } mph_t;

  // Steps of the per-sample sequencer.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V,
    ST_HP_GO,
    ST_HP,
    ST_U1_GO,
    ST_U1,
    ST_BP,
    ST_S1,
    ST_U2,
    ST_LP,
    ST_AP,
    ST_OUT
  } st_t;

endpackage

`default_nettype wire

[hw/rtl/improved_svf_multimode.sv]
// Top level of the trapezoidal state variable filter with five outputs.
`default_nettype none
`include "improved_svf_multimode_assert.svh"

// Multimode state variable filter. Each accepted beat on the in_ channel is one
// signed sample; one beat on the out_ channel later carries the saturated
// highpass, bandpass, lowpass, notch and allpass outputs. All five coefficient
// products go one after another through a single rounding multiplier that
// splits its operand into two halves. A new sample is taken only once the last
// result has moved into the output register. A finished result waits in that
// output register while the next sample is taken. The user must write
// coefficients through the cfg_ port only while no sample is in flight; the
// block itself does not enforce this.
module improved_svf_multimode
  import isvf_pkg::*;
#(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int COEFF_FRAC_BITS = 16,
  parameter int STATE_WIDTH     = 40
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0]    in_sample_in,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]   out_highpass,
  output logic signed [SAMPLE_WIDTH-1:0]   out_bandpass,
  output logic signed [SAMPLE_WIDTH-1:0]   out_lowpass,
  output logic signed [SAMPLE_WIDTH-1:0]   out_notch,
  output logic signed [SAMPLE_WIDTH-1:0]   out_allpass,
  input  wire                              cfg_we,
  input  wire        [CFG_IDX_W-1:0]       cfg_index,
  input  wire        [COEFF_FRAC_BITS+8:0] cfg_wdata
);

  localparam int F   = COEFF_FRAC_BITS;
  localparam int SW  = SAMPLE_WIDTH;
  localparam int TW  = STATE_WIDTH;
  localparam int IW  = TW + 12;
  localparam int XW  = IW + 2;
  localparam int CW  = F + 9;
  localparam int DW  = F + 4;
  localparam int GW  = F + 1;
  localparam int KW  = F + 10;
  localparam int DampRstInt = (F >= DAMP_RESET_FRAC) ?
                              (DAMP_RESET_Q16 << (F - DAMP_RESET_FRAC)) :
                              (DAMP_RESET_Q16 >> (DAMP_RESET_FRAC - F));
  localparam logic [DW-1:0] DAMP_RST = DW'(DampRstInt);
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {F{1'b0}}};
  localparam logic signed [XW-1:0] STATE_MAX = {{(XW-TW+1){1'b0}}, {(TW-1){1'b1}}};
  localparam logic signed [XW-1:0] STATE_MIN = {{(XW-TW+1){1'b1}}, {(TW-1){1'b0}}};
  localparam logic signed [XW-1:0] SMP_MAX   = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [XW-1:0] SMP_MIN   = {{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}};

  // Clamp a wide value to the integrator range.
  function automatic logic signed [TW-1:0] sat_state(input logic signed [XW-1:0] v);
    logic signed [TW-1:0] r;
    if (v > STATE_MAX) r = STATE_MAX[TW-1:0];
    else if (v < STATE_MIN) r = STATE_MIN[TW-1:0];
    else r = v[TW-1:0];
    return r;
  endfunction

  // Clamp a wide value to the sample range.
  function automatic logic signed [SW-1:0] sat_smp(input logic signed [XW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > SMP_MAX) r = SMP_MAX[SW-1:0];
    else if (v < SMP_MIN) r = SMP_MIN[SW-1:0];
    else r = v[SW-1:0];
    return r;
  endfunction

  // Sign-extend an integrator-wide value.
  function automatic logic signed [XW-1:0] ext_t(input logic signed [TW-1:0] v);
    return {{(XW-TW){v[TW-1]}}, v};
  endfunction

  st_t state_r, state_nxt;

  logic [CW-1:0] cutoff_r;
  logic [DW-1:0] damping_r;
  logic [GW-1:0] gain_r;

  logic signed [SW-1:0] x_r;
  logic signed [TW-1:0] s1_r, s2_r;
  logic signed [XW-1:0] v_r, ap_r;
  logic signed [TW-1:0] hp_r, u1_r, bp_r, u2_r, lp_r;

  logic                 mul_start;
  logic signed [XW-1:0] mul_op;
  logic [KW-1:0]        mul_coef;
  logic                 mul_done;
  logic signed [IW-1:0] mul_res;
  logic signed [XW-1:0] res_x;
  logic                 out_load;
  logic                 out_valid_r;

  assign res_x = {{(XW-IW){mul_res[IW-1]}}, mul_res};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= '0;
      damping_r <= DAMP_RST;
      gain_r    <= GAIN_ONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUTOFF:  cutoff_r  <= cfg_wdata;
        REG_DAMPING: damping_r <= cfg_wdata[DW-1:0];
        REG_GAIN:    gain_r    <= cfg_wdata[GW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next step.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_V;
      ST_V:     if (mul_done) state_nxt = ST_HP_GO;
      ST_HP_GO: state_nxt = ST_HP;
      ST_HP:    if (mul_done) state_nxt = ST_U1_GO;
      ST_U1_GO: state_nxt = ST_U1;
      ST_U1:    if (mul_done) state_nxt = ST_BP;
      ST_BP:    state_nxt = ST_S1;
      ST_S1:    state_nxt = ST_U2;
      ST_U2:    if (mul_done) state_nxt = ST_LP;
      ST_LP:    state_nxt = ST_AP;
      ST_AP:    if (mul_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier launch.
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_op    = ext_t(s1_r);
    mul_coef  = KW'(damping_r) + KW'(cutoff_r);
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        mul_start = in_valid;
      end
      ST_HP_GO: begin
        mul_start = 1'b1;
        mul_op    = v_r;
        mul_coef  = KW'(gain_r);
      end
      ST_U1_GO: begin
        mul_start = 1'b1;
        mul_op    = ext_t(hp_r);
        mul_coef  = KW'(cutoff_r);
      end
      ST_S1: begin
        mul_start = 1'b1;
        mul_op    = ext_t(bp_r);
        mul_coef  = KW'(cutoff_r);
      end
      ST_LP: begin
        mul_start = 1'b1;
        mul_op    = ext_t(bp_r);
        mul_coef  = KW'(damping_r);
      end
      ST_OUT: out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Integrator states.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else begin
      if (state_r == ST_S1) begin
        s1_r <= sat_state(ext_t(u1_r) + ext_t(bp_r));
      end
      if (state_r == ST_AP && mul_done) begin
        s2_r <= sat_state(ext_t(u2_r) + ext_t(lp_r));
      end
    end
  end

  // Intermediate filter values, one step at a time.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_valid) x_r <= in_sample_in;
      ST_V: begin
        if (mul_done) begin
          v_r <= {{(XW-SW){x_r[SW-1]}}, x_r} - res_x - ext_t(s2_r);
        end
      end
      ST_HP: if (mul_done) hp_r <= sat_state(res_x);
      ST_U1: if (mul_done) u1_r <= sat_state(res_x);
      ST_BP: bp_r <= sat_state(ext_t(u1_r) + ext_t(s1_r));
      ST_U2: if (mul_done) u2_r <= sat_state(res_x);
      ST_LP: lp_r <= sat_state(ext_t(u2_r) + ext_t(s2_r));
      ST_AP: if (mul_done) ap_r <= ext_t(hp_r) + ext_t(lp_r) + res_x;
      default: ;
    endcase
  end

  // Output register; the next sample may be taken while this beat waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_highpass <= sat_smp(ext_t(hp_r));
      out_bandpass <= sat_smp(ext_t(bp_r));
      out_lowpass  <= sat_smp(ext_t(lp_r));
      out_notch    <= sat_smp(ext_t(hp_r) + ext_t(lp_r));
      out_allpass  <= sat_smp(ap_r);
    end
  end

  assign out_valid = out_valid_r;

  isvf_cmul #(
    .MW(XW),
    .KW(KW),
    .F (F),
    .IW(IW)
  ) u_cmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .op_a  (mul_op),
    .coeff (mul_coef),
    .done  (mul_done),
    .result(mul_res)
  );

  `ISVF_ASSERT(a_accept_starts, in_valid && in_ready |=> state_r == ST_V,
               "accepted sample did not start the sequence")
  `ISVF_ASSERT(a_done_when_waiting,
               mul_done |-> (state_r == ST_V || state_r == ST_HP || state_r == ST_U1 ||
                             state_r == ST_U2 || state_r == ST_AP),
               "multiplier result arrived outside a waiting step")
  `ISVF_ASSERT(a_load_sets_valid, out_load |=> out_valid_r && state_r == ST_IDLE,
               "result load did not present a beat")

endmodule

`default_nettype wire

[hw/rtl/isvf_cmul.sv]
// Shared multiplier: signed value times unsigned coefficient, rounded and saturated.
`default_nettype none
`include "improved_svf_multimode_assert.svh"

module isvf_cmul
  import isvf_pkg::*;
#(
  parameter int MW = 54,  // operand width, signed
  parameter int KW = 26,  // coefficient width, unsigned
  parameter int F  = 16,  // coefficient fraction bits
  parameter int IW = 52   // result width, signed
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire signed [MW-1:0]  op_a,
  input  wire        [KW-1:0]  coeff,
  output logic                 done,
  output logic signed [IW-1:0] result
);

  localparam int HW  = (MW + 1) / 2;
  localparam int HIW = MW - HW;
  localparam int PLW = HW + KW;
  localparam int PHW = HIW + KW;
  localparam int PW  = MW + KW + 1;
  localparam int QW  = PW - F;
  localparam logic [PW-1:0] ROUND = {{(PW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [QW-1:0] CAP   = {{(QW-IW+1){1'b0}}, {(IW-1){1'b1}}};

  mph_t phase_r, phase_nxt;

  logic          ld_op, do_lo, do_hi, do_sum, do_neg;
  logic          neg_r;
  logic [MW-1:0] mag_r;
  logic [KW-1:0] coef_r;
  logic [PLW-1:0] plo_r;
  logic [PHW-1:0] phi_r;
  logic [PW-1:0]  acc_r;
  logic [IW-2:0]  mres_r;
  logic [PW-1:0]  sum;
  logic [QW-1:0]  quo;
  logic           done_r;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      MP_IDLE: if (start) phase_nxt = MP_LO;
      MP_LO:   phase_nxt = MP_HI;
      MP_HI:   phase_nxt = MP_SUM;
      MP_SUM:  phase_nxt = MP_NEG;
      MP_NEG:  phase_nxt = MP_IDLE;
      default: phase_nxt = MP_IDLE;
    endcase
  end

  // Phase decode.
  always_comb begin
    ld_op  = 1'b0;
    do_lo  = 1'b0;
    do_hi  = 1'b0;
    do_sum = 1'b0;
    do_neg = 1'b0;
    case (phase_r)
      MP_IDLE: ld_op  = start;
      MP_LO:   do_lo  = 1'b1;
      MP_HI:   do_hi  = 1'b1;
      MP_SUM:  do_sum = 1'b1;
      MP_NEG:  do_neg = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= MP_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= do_neg;
    end
  end

  // Combine the two partial products and round to the coefficient's fraction.
  assign sum = acc_r + (PW'(phi_r) << HW);
  assign quo = sum[PW-1:F];

  // Operand capture, two partial products, rounding, saturation and sign restore.
  always_ff @(posedge clk) begin
    if (ld_op) begin
      neg_r  <= op_a[MW-1];
      mag_r  <= op_a[MW-1] ? (MW'(0) - op_a) : op_a;
      coef_r <= coeff;
    end
    if (do_lo) begin
      plo_r <= mag_r[HW-1:0] * coef_r;
    end
    if (do_hi) begin
      acc_r <= PW'(plo_r) + ROUND;
      phi_r <= mag_r[MW-1:HW] * coef_r;
    end
    if (do_sum) begin
      mres_r <= (quo > CAP) ? CAP[IW-2:0] : quo[IW-2:0];
    end
    if (do_neg) begin
      result <= neg_r ? (IW'(0) - {1'b0, mres_r}) : {1'b0, mres_r};
    end
  end

  assign done = done_r;

  `ISVF_ASSERT(a_start_idle, start |-> phase_r == MP_IDLE,
               "multiplier started while busy")
  `ISVF_ASSERT(a_done_after_neg, done_r |-> $past(phase_r == MP_NEG),
               "done without a sign restore phase")
  `ISVF_ASSERT(a_lo_after_start, phase_r == MP_LO |-> $past(start),
               "low partial product without a start")

endmodule

`default_nettype wire
